@@ src/nfc_pkg.sv @@
// ----------------------------------------------------------------------------
// nfc_pkg
// shared constants, codes and types of the nand flash command interface
// ----------------------------------------------------------------------------
package nfc_pkg;

    localparam int NUM_BLOCKS      = 4;
    localparam int BLK_PAGES       = 64;
    localparam int PAGE_BYTES      = 2112;

    localparam int NUM_PAGES   = NUM_BLOCKS * BLK_PAGES;
    localparam int BLOCK_BYTES = BLK_PAGES * PAGE_BYTES;
    localparam int ARRAY_BYTES = NUM_BLOCKS * BLOCK_BYTES;

    localparam int FA_W  = $clog2(ARRAY_BYTES);
    localparam int PB_W  = $clog2(PAGE_BYTES);
    localparam int CNT_W = $clog2(ARRAY_BYTES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_VALUE = 2'd1;

    localparam logic [7:0] CMD_READ       = 8'h00;
    localparam logic [7:0] CMD_READ_CONF  = 8'h30;
    localparam logic [7:0] CMD_RND_READ   = 8'h05;
    localparam logic [7:0] CMD_RND_CONF   = 8'hE0;
    localparam logic [7:0] CMD_PROG       = 8'h80;
    localparam logic [7:0] CMD_PROG_RND   = 8'h85;
    localparam logic [7:0] CMD_PROG_CONF  = 8'h10;
    localparam logic [7:0] CMD_ERASE      = 8'h60;
    localparam logic [7:0] CMD_ERASE_CONF = 8'hD0;
    localparam logic [7:0] CMD_STATUS     = 8'h70;
    localparam logic [7:0] CMD_RST        = 8'hFF;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [7:0] COL_HI_MASK = 8'h0F;
    localparam logic [7:0] ROW_HI_MASK = 8'h03;

    localparam logic [2:0] OP_COMMAND = 3'd0;
    localparam logic [2:0] OP_ADDRESS = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } sweep_ctrl_t;

    typedef struct packed {
        logic             issue;
        logic [CNT_W-1:0] issue_idx;
        logic             wr;
        logic [CNT_W-1:0] wr_idx;
        logic             done;
    } sweep_stat_t;

endpackage

@@ src/nfc_if.sv @@
// ----------------------------------------------------------------------------
// nfc_in_if / nfc_out_if
// valid/ready channels for accesses and results
// ----------------------------------------------------------------------------
interface nfc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface nfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       busy_res;
    logic       data_ready;
    modport source (output valid, output read_data, output busy_res, output data_ready,
                    input ready);
    modport sink   (input valid, input read_data, input busy_res, input data_ready,
                    output ready);
endinterface

@@ src/nfc_ram.sv @@
// ----------------------------------------------------------------------------
// nfc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/nfc_sweep.sv @@
// ----------------------------------------------------------------------------
// nfc_sweep
// index sequencer for memory walks: read issue stage and write-back stage
// ----------------------------------------------------------------------------
module nfc_sweep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nfc_pkg::sweep_ctrl_t ctrl,
    output nfc_pkg::sweep_stat_t stat
);
    import nfc_pkg::*;

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] len_reg;
    logic             wr_reg;
    logic             last_reg;
    logic [CNT_W-1:0] wr_idx_reg;
    logic             at_end;

    assign at_end = (cnt_reg == len_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            wr_reg     <= 1'b0;
            last_reg   <= 1'b0;
            cnt_reg    <= '0;
            len_reg    <= CNT_W'(1);
            wr_idx_reg <= '0;
        end
        else
        begin
            wr_reg     <= run_reg;
            last_reg   <= run_reg && at_end;
            wr_idx_reg <= cnt_reg;
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                len_reg <= ctrl.len;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (at_end)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.issue     = run_reg;
    assign stat.issue_idx = cnt_reg;
    assign stat.wr        = wr_reg;
    assign stat.wr_idx    = wr_idx_reg;
    assign stat.done      = wr_reg && last_reg;

endmodule

@@ src/nand_flash_command_interface.sv @@
// ----------------------------------------------------------------------------
// nand_flash_command_interface
// byte-wide nand flash device with page buffer, program buffer and array
// ----------------------------------------------------------------------------
// Each access is taken only while the device is idle, and the result of a plain
// command, address, data or tick access is registered in the next cycle.
// Anything that walks a memory goes one byte per cycle through simple dual-port
// byte-wide rams before its result: page read (30) walks a page, program (10)
// a page and erase (D0) a block when in range, and 80 the program buffer. After
// reset a clearing pass writes FF through the whole array and both buffers,
// during which no access is taken; configuration writes are taken at any time.
module nand_flash_command_interface (
    input  logic                          clk,
    input  logic                          rst_n,
    nfc_in_if.sink                        in,
    nfc_out_if.source                     out,
    input  logic                          cfg_we,
    input  logic [nfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nfc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import nfc_pkg::*;

    typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_SWEEP, ST_FINISH} state_t;
    typedef enum logic [2:0] {
        MD_CLEAR, MD_COPY, MD_FILL_PAGE, MD_PROG, MD_ERASE, MD_FILL_PROG
    } mode_t;
    typedef enum logic [1:0] {RK_ZERO, RK_STATUS, RK_PAGE, RK_ERASED} rd_kind_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    rd_kind_t   kind_reg, kind_next;
    logic [7:0] store_reg [5];
    logic [7:0] store_next [5];
    logic [2:0] acnt_reg, acnt_next;
    logic [11:0] cp_reg, cp_next;
    logic [7:0] last_reg, last_next;
    logic [7:0] busy_reg, busy_next;
    logic [7:0] ticks_reg;
    logic [7:0] status_reg;
    logic [FA_W-1:0] base_reg, base_next;
    logic       pw_en_reg, pw_en_next;
    logic [PB_W-1:0] pw_ptr_reg, pw_ptr_next;
    logic [7:0] val_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_rd_reg, out_rd_next;
    logic       out_busy_reg, out_busy_next;
    logic       out_dr_reg, out_dr_next;

    sweep_ctrl_t sw_ctrl;
    sweep_stat_t sw_stat;

    logic        fl_we, pg_we, pr_we;
    logic [FA_W-1:0] fl_waddr, fl_raddr;
    logic [PB_W-1:0] pg_waddr, pr_waddr, pg_raddr, pr_raddr;
    logic [7:0]  fl_wdata, pg_wdata, pr_wdata;
    logic [7:0]  fl_rdata, pg_rdata, pr_rdata;

    logic        accept;
    logic        cp_in_page;
    logic [11:0] col_cur, col_new;
    logic [17:0] row_cur;
    logic [17:0] blk_cur;
    logic        wr_in_page;
    logic [7:0]  and_byte;

    assign in.ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out.ready);
    assign accept     = in.valid && in.ready;
    assign cp_in_page = {1'b0, cp_reg} < 13'(PAGE_BYTES);
    assign col_cur    = {store_reg[1][3:0] & COL_HI_MASK[3:0], store_reg[0]};
    assign col_new    = {store_next[1][3:0] & COL_HI_MASK[3:0], store_next[0]};
    assign row_cur    = {store_reg[4][1:0] & ROW_HI_MASK[1:0], store_reg[3], store_reg[2]};
    assign blk_cur    = 18'(row_cur / BLK_PAGES);
    assign wr_in_page = sw_stat.wr_idx < CNT_W'(PAGE_BYTES);
    assign and_byte   = fl_rdata & pr_rdata;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        kind_next      = kind_reg;
        store_next     = store_reg;
        acnt_next      = acnt_reg;
        cp_next        = cp_reg;
        last_next      = last_reg;
        busy_next      = busy_reg;
        base_next      = base_reg;
        pw_en_next     = pw_en_reg;
        pw_ptr_next    = pw_ptr_reg;
        out_valid_next = out_valid_reg && !out.ready;
        out_rd_next    = out_rd_reg;
        out_busy_next  = out_busy_reg;
        out_dr_next    = out_dr_reg;
        sw_ctrl.start  = 1'b0;
        sw_ctrl.len    = CNT_W'(PAGE_BYTES);
        unique case (state_reg)
            ST_INIT:
            begin
                sw_ctrl.start = 1'b1;
                sw_ctrl.len   = CNT_W'(ARRAY_BYTES);
                mode_next     = MD_CLEAR;
                base_next     = '0;
                state_next    = ST_SWEEP;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = RK_ZERO;
                    pw_en_next = 1'b0;
                    state_next = ST_FINISH;
                    case (in.opcode)
                        OP_COMMAND:
                        begin
                            acnt_next = '0;
                            last_next = in.value;
                            unique case (in.value)
                                CMD_RST:
                                begin
                                    cp_next   = '0;
                                    busy_next = ticks_reg;
                                end
                                CMD_READ_CONF:
                                begin
                                    if (last_reg == CMD_READ)
                                    begin
                                        busy_next     = ticks_reg;
                                        cp_next       = col_cur;
                                        sw_ctrl.start = 1'b1;
                                        state_next    = ST_SWEEP;
                                        base_next     = FA_W'(32'(row_cur) * 32'(PAGE_BYTES));
                                        if (32'(row_cur) < 32'(NUM_PAGES))
                                        begin
                                            mode_next = MD_COPY;
                                        end
                                        else
                                        begin
                                            mode_next = MD_FILL_PAGE;
                                        end
                                    end
                                end
                                CMD_RND_CONF:
                                begin
                                    if (last_reg == CMD_RND_READ)
                                    begin
                                        cp_next = col_cur;
                                    end
                                end
                                CMD_ERASE:
                                begin
                                    acnt_next = 3'd2;
                                end
                                CMD_ERASE_CONF:
                                begin
                                    if (last_reg == CMD_ERASE)
                                    begin
                                        busy_next = ticks_reg;
                                        if (32'(blk_cur) < 32'(NUM_BLOCKS))
                                        begin
                                            mode_next     = MD_ERASE;
                                            base_next     = FA_W'(32'(blk_cur) * 32'(BLOCK_BYTES));
                                            sw_ctrl.start = 1'b1;
                                            sw_ctrl.len   = CNT_W'(BLOCK_BYTES);
                                            state_next    = ST_SWEEP;
                                        end
                                    end
                                end
                                CMD_PROG:
                                begin
                                    cp_next       = '0;
                                    mode_next     = MD_FILL_PROG;
                                    sw_ctrl.start = 1'b1;
                                    state_next    = ST_SWEEP;
                                end
                                CMD_PROG_RND:
                                begin
                                    cp_next = '0;
                                end
                                CMD_PROG_CONF:
                                begin
                                    if (last_reg == CMD_PROG || last_reg == CMD_PROG_RND)
                                    begin
                                        busy_next = ticks_reg;
                                        if (32'(row_cur) < 32'(NUM_PAGES))
                                        begin
                                            mode_next     = MD_PROG;
                                            base_next     = FA_W'(32'(row_cur) * 32'(PAGE_BYTES));
                                            sw_ctrl.start = 1'b1;
                                            state_next    = ST_SWEEP;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        OP_ADDRESS:
                        begin
                            if (acnt_reg < 3'd5)
                            begin
                                store_next[acnt_reg] = in.value;
                                acnt_next            = acnt_reg + 3'd1;
                            end
                            if (last_reg == CMD_PROG_RND && acnt_next == 3'd2)
                            begin
                                cp_next = col_new;
                            end
                            else if (last_reg == CMD_PROG && acnt_next == 3'd5)
                            begin
                                cp_next = col_new;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (cp_in_page)
                            begin
                                pw_en_next  = 1'b1;
                                pw_ptr_next = cp_reg[PB_W-1:0];
                                cp_next     = cp_reg + 12'd1;
                            end
                        end
                        OP_READ:
                        begin
                            if (last_reg == CMD_STATUS)
                            begin
                                kind_next = RK_STATUS;
                            end
                            else if (cp_in_page)
                            begin
                                kind_next = RK_PAGE;
                                cp_next   = cp_reg + 12'd1;
                            end
                            else
                            begin
                                kind_next = RK_ERASED;
                            end
                        end
                        OP_TICK:
                        begin
                            if (busy_reg != 8'd0)
                            begin
                                busy_next = busy_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sw_stat.done)
                begin
                    state_next = (mode_reg == MD_CLEAR) ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                out_valid_next = 1'b1;
                out_busy_next  = busy_reg != 8'd0;
                if (last_reg == CMD_READ_CONF)
                begin
                    out_dr_next = cp_in_page;
                end
                else
                begin
                    out_dr_next = last_reg == CMD_STATUS;
                end
                case (kind_reg)
                    RK_STATUS: out_rd_next = status_reg;
                    RK_PAGE:   out_rd_next = pg_rdata;
                    RK_ERASED: out_rd_next = ERASED_BYTE;
                    default:   out_rd_next = 8'd0;
                endcase
                pw_en_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            mode_reg      <= MD_CLEAR;
            kind_reg      <= RK_ZERO;
            for (int i = 0; i < 5; i++)
            begin
                store_reg[i] <= 8'd0;
            end
            acnt_reg      <= '0;
            cp_reg        <= '0;
            last_reg      <= 8'd0;
            busy_reg      <= 8'd0;
            ticks_reg     <= 8'd1;
            status_reg    <= 8'd192;
            base_reg      <= '0;
            pw_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            kind_reg      <= kind_next;
            store_reg     <= store_next;
            acnt_reg      <= acnt_next;
            cp_reg        <= cp_next;
            last_reg      <= last_next;
            busy_reg      <= busy_next;
            base_reg      <= base_next;
            pw_en_reg     <= pw_en_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_BUSY_TICKS)
            begin
                ticks_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_STATUS_VALUE)
            begin
                status_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pw_ptr_reg   <= pw_ptr_next;
        out_rd_reg   <= out_rd_next;
        out_busy_reg <= out_busy_next;
        out_dr_reg   <= out_dr_next;
        if (accept)
        begin
            val_reg <= in.value;
        end
    end

    // memory ports
    always_comb
    begin
        fl_raddr = base_reg + sw_stat.issue_idx[FA_W-1:0];
        fl_waddr = base_reg + sw_stat.wr_idx[FA_W-1:0];
        fl_we    = sw_stat.wr &&
                   (mode_reg == MD_CLEAR || mode_reg == MD_PROG || mode_reg == MD_ERASE);
        fl_wdata = (mode_reg == MD_PROG) ? and_byte : ERASED_BYTE;

        pg_raddr = cp_reg[PB_W-1:0];
        pg_waddr = sw_stat.wr_idx[PB_W-1:0];
        pg_we    = sw_stat.wr && (mode_reg == MD_COPY || mode_reg == MD_FILL_PAGE ||
                   mode_reg == MD_PROG || (mode_reg == MD_CLEAR && wr_in_page));
        case (mode_reg)
            MD_COPY: pg_wdata = fl_rdata;
            MD_PROG: pg_wdata = and_byte;
            default: pg_wdata = ERASED_BYTE;
        endcase

        pr_raddr = (state_reg == ST_SWEEP) ? sw_stat.issue_idx[PB_W-1:0] : cp_reg[PB_W-1:0];
        if (state_reg == ST_FINISH)
        begin
            pr_we    = pw_en_reg;
            pr_waddr = pw_ptr_reg;
            pr_wdata = pr_rdata & val_reg;
        end
        else
        begin
            pr_we    = sw_stat.wr &&
                       (mode_reg == MD_FILL_PROG || (mode_reg == MD_CLEAR && wr_in_page));
            pr_waddr = sw_stat.wr_idx[PB_W-1:0];
            pr_wdata = ERASED_BYTE;
        end
    end

    nfc_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sw_ctrl),
        .stat  (sw_stat)
    );

    nfc_ram #(.WIDTH(8), .DEPTH(ARRAY_BYTES)) u_array (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    nfc_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_buf (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    nfc_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_prog_buf (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    assign out.valid      = out_valid_reg;
    assign out.read_data  = out_rd_reg;
    assign out.busy_res   = out_busy_reg;
    assign out.data_ready = out_dr_reg;

endmodule

@@ src/nfc_checker.sv @@
// ----------------------------------------------------------------------------
// nfc_checker
// port-level checks of the nand flash command interface
// ----------------------------------------------------------------------------
module nfc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // no access taken while reset is asserted
    a_no_accept_in_reset: assert property (@(posedge clk) !rst_n |-> !in_ready)
        else $error("access taken during reset");

    // an access is only taken when the result register is free or being emptied
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("access taken while a result is stalled");

    // one result per access, never two back to back
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");

    // a stalled result stays presented
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("stalled result dropped");

endmodule

bind nand_flash_command_interface nfc_checker u_nfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready)
);

@@ tb/tb_nand_flash_command_interface.sv @@
// ----------------------------------------------------------------------------
// tb_nand_flash_command_interface
// self-checking bench for the nand flash command interface: directed command
// sequences, then phases of random well-formed read, program, status and reset
// sequences mixed with noise, under several idle, stall and register settings;
// every result is checked against a model of the device kept in the bench
// ----------------------------------------------------------------------------
module tb_nand_flash_command_interface;
    timeunit 1ns;
    timeprecision 1ps;

    import nfc_pkg::*;

    typedef logic [7:0] page_t [PAGE_BYTES];

    typedef struct packed {
        logic [7:0] read_data;
        logic       busy_res;
        logic       data_ready;
    } access_result_t;

    class flash_scoreboard;
        page_t          pages [int];
        page_t          page_buf;
        page_t          prog_buf;
        logic [7:0]     addr_bytes [5];
        int             addr_cnt;
        logic [11:0]    col_ptr;
        logic [7:0]     last_cmd;
        logic [7:0]     busy_cnt;
        logic [7:0]     busy_ticks;
        logic [7:0]     status_val;
        access_result_t expected_q [$];
        int             errors;

        function new();
            foreach (page_buf[i])
            begin
                page_buf[i] = ERASED_BYTE;
                prog_buf[i] = ERASED_BYTE;
            end
            foreach (addr_bytes[i])
                addr_bytes[i] = 8'h00;
            addr_cnt   = 0;
            col_ptr    = '0;
            last_cmd   = CMD_READ;
            busy_cnt   = 8'd0;
            busy_ticks = 8'd1;
            status_val = 8'hC0;
            errors     = 0;
        endfunction

        function int column();
            return {addr_bytes[1] & COL_HI_MASK, addr_bytes[0]};
        endfunction

        function int row();
            return int'(addr_bytes[2]) | (int'(addr_bytes[3]) << 8)
                   | (int'(addr_bytes[4] & ROW_HI_MASK) << 16);
        endfunction

        function void apply_command(logic [7:0] cmd);
            int r;
            int blk;
            page_t pg;
            r = row();
            addr_cnt = 0;
            case (cmd)
                CMD_RST:
                begin
                    col_ptr  = '0;
                    busy_cnt = busy_ticks;
                end
                CMD_READ_CONF:
                    if (last_cmd == CMD_READ)
                    begin
                        busy_cnt = busy_ticks;
                        if (r < NUM_PAGES && pages.exists(r))
                            page_buf = pages[r];
                        else
                            foreach (page_buf[i])
                                page_buf[i] = ERASED_BYTE;
                        col_ptr = column();
                    end
                CMD_RND_CONF:
                    if (last_cmd == CMD_RND_READ)
                        col_ptr = column();
                CMD_ERASE:
                    addr_cnt = 2;
                CMD_ERASE_CONF:
                    if (last_cmd == CMD_ERASE)
                    begin
                        blk = r / BLK_PAGES;
                        busy_cnt = busy_ticks;
                        if (blk < NUM_BLOCKS)
                            for (int p = 0; p < BLK_PAGES; p++)
                                pages.delete(blk * BLK_PAGES + p);
                    end
                CMD_PROG:
                begin
                    col_ptr = '0;
                    foreach (prog_buf[i])
                        prog_buf[i] = ERASED_BYTE;
                end
                CMD_PROG_RND:
                    col_ptr = '0;
                CMD_PROG_CONF:
                    if (last_cmd == CMD_PROG || last_cmd == CMD_PROG_RND)
                    begin
                        busy_cnt = busy_ticks;
                        if (r < NUM_PAGES)
                        begin
                            if (pages.exists(r))
                                pg = pages[r];
                            else
                                foreach (pg[i])
                                    pg[i] = ERASED_BYTE;
                            foreach (pg[i])
                                pg[i] = pg[i] & prog_buf[i];
                            pages[r] = pg;
                            page_buf = pg;
                        end
                    end
                default:
                    ;
            endcase
            last_cmd = cmd;
        endfunction

        function access_result_t predict_access(logic [2:0] op, logic [7:0] v);
            access_result_t res;
            res.read_data = 8'h00;
            case (op)
                OP_COMMAND:
                    apply_command(v);
                OP_ADDRESS:
                begin
                    if (addr_cnt < 5)
                    begin
                        addr_bytes[addr_cnt] = v;
                        addr_cnt++;
                    end
                    if (last_cmd == CMD_PROG_RND && addr_cnt == 2)
                        col_ptr = column();
                    else if (last_cmd == CMD_PROG && addr_cnt == 5)
                        col_ptr = column();
                end
                OP_WRITE:
                    if (col_ptr < PAGE_BYTES)
                    begin
                        prog_buf[col_ptr] = prog_buf[col_ptr] & v;
                        col_ptr = col_ptr + 12'd1;
                    end
                OP_READ:
                    if (last_cmd == CMD_STATUS)
                        res.read_data = status_val;
                    else if (col_ptr < PAGE_BYTES)
                    begin
                        res.read_data = page_buf[col_ptr];
                        col_ptr = col_ptr + 12'd1;
                    end
                    else
                        res.read_data = ERASED_BYTE;
                OP_TICK:
                    if (busy_cnt != 8'd0)
                        busy_cnt--;
                default:
                    ;
            endcase
            res.busy_res = busy_cnt != 8'd0;
            if (last_cmd == CMD_READ_CONF)
                res.data_ready = col_ptr < PAGE_BYTES;
            else
                res.data_ready = last_cmd == CMD_STATUS;
            return res;
        endfunction

        function void note_access(logic [2:0] op, logic [7:0] v);
            expected_q.push_back(predict_access(op, v));
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(access_result_t got);
            access_result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.busy_res !== want.busy_res)
                report("busy_res", got.busy_res, want.busy_res);
            if (got.data_ready !== want.data_ready)
                report("data_ready", got.data_ready, want.data_ready);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    nfc_in_if  in_ch ();
    nfc_out_if out_ch ();

    nand_flash_command_interface uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    flash_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_cycles;
    int items_sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #96000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: check each transfer, then decide ready for the next cycle
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.read_data, out_ch.busy_res, out_ch.data_ready});
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= $urandom_range(99) >= receiver_stall_pct;
        end
    end

    task automatic send(logic [2:0] op, logic [7:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_access(op, v);
        items_sent++;
    endtask

    task automatic send_addr(int col, int row, int n);
        logic [7:0] bytes [5];
        int first;
        bytes[0] = col[7:0];
        bytes[1] = {4'($urandom), col[11:8]};
        bytes[2] = row[7:0];
        bytes[3] = row[15:8];
        bytes[4] = {6'($urandom), row[17:16]};
        first = (n == 2) ? 0 : 5 - n;
        for (int i = first; i < first + n; i++)
            send(OP_ADDRESS, bytes[i]);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(logic [7:0] ticks, logic [7:0] status);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BUSY_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= CFG_STATUS_VALUE;
        cfg_data  <= status;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.busy_ticks = ticks;
        sb.status_val = status;
    endtask

    function automatic int pick_column();
        case ($urandom_range(2))
            0: return $urandom_range(15);
            1: return $urandom_range(PAGE_BYTES - 1, PAGE_BYTES - 12);
            default: return $urandom_range(4095);
        endcase
    endfunction

    function automatic int pick_row();
        if ($urandom_range(9) == 0)
            return $urandom_range(262143);
        return $urandom_range(3) * 64 + $urandom_range(2);
    endfunction

    task automatic random_sequence();
        int n;
        logic [7:0] v;
        case ($urandom_range(99)) inside
            [0:24]:
            begin
                send(OP_COMMAND, CMD_READ);
                send_addr(pick_column(), pick_row(), 5);
                send(OP_COMMAND, CMD_READ_CONF);
                repeat ($urandom_range(3)) send(OP_TICK, 8'($urandom));
                repeat ($urandom_range(6)) send(OP_READ, 8'($urandom));
                if ($urandom_range(2) == 0)
                begin
                    send(OP_COMMAND, CMD_RND_READ);
                    send_addr(pick_column(), 0, 2);
                    send(OP_COMMAND, CMD_RND_CONF);
                    repeat ($urandom_range(4)) send(OP_READ, 8'($urandom));
                end
            end
            [25:44]:
            begin
                send(OP_COMMAND, CMD_PROG);
                send_addr(pick_column(), pick_row(), 5);
                repeat ($urandom_range(6)) send(OP_WRITE, 8'($urandom));
                if ($urandom_range(2) == 0)
                begin
                    send(OP_COMMAND, CMD_PROG_RND);
                    send_addr(pick_column(), 0, 2);
                    repeat ($urandom_range(4)) send(OP_WRITE, 8'($urandom));
                end
                send(OP_COMMAND, CMD_PROG_CONF);
                repeat ($urandom_range(3)) send(OP_TICK, 8'($urandom));
            end
            [45:54]:
            begin
                send(OP_COMMAND, CMD_STATUS);
                repeat ($urandom_range(1, 3)) send(OP_READ, 8'($urandom));
            end
            [55:59]:
                send(OP_COMMAND, CMD_RST);
            [60:69]:
                repeat ($urandom_range(1, 5)) send(OP_TICK, 8'($urandom));
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    v = 8'($urandom);
                    if (v == CMD_ERASE_CONF)
                        v = 8'hD1;
                    send(3'($urandom), v);
                end
            end
        endcase
    endtask

    initial
    begin
        sb = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 0;
        items_sent         = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BUSY_TICKS;
        cfg_data     = 8'h00;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_TICK;
        in_ch.value  = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_COMMAND, CMD_RST);
        send(OP_TICK, 8'h00);
        send(OP_COMMAND, CMD_STATUS);
        send(OP_READ, 8'h00);
        send(OP_COMMAND, CMD_PROG);
        send_addr(0, 65, 5);
        send(OP_WRITE, 8'h00);
        send(OP_WRITE, 8'hA5);
        send(OP_COMMAND, CMD_PROG_CONF);
        send(OP_COMMAND, CMD_READ);
        send_addr(0, 65, 5);
        send(OP_ADDRESS, 8'hFF);
        send(OP_COMMAND, CMD_READ_CONF);
        send(OP_READ, 8'hFF);
        send(OP_READ, 8'h00);
        send(OP_COMMAND, CMD_RND_READ);
        send_addr(PAGE_BYTES - 1, 0, 2);
        send(OP_COMMAND, CMD_RND_CONF);
        send(OP_READ, 8'h00);
        send(OP_READ, 8'h00);
        send(OP_COMMAND, CMD_PROG_CONF);
        send(3'd7, 8'hFF);
        send(OP_COMMAND, 8'h42);
        send(OP_COMMAND, CMD_ERASE_CONF);
        send(OP_COMMAND, CMD_ERASE);
        send_addr(0, 64, 3);
        send(OP_COMMAND, CMD_ERASE_CONF);
        send(OP_COMMAND, CMD_READ);
        send_addr(1, 65, 5);
        send(OP_COMMAND, CMD_READ_CONF);
        send(OP_READ, 8'h00);
        send(OP_COMMAND, CMD_READ);
        send_addr(0, 200000, 5);
        send(OP_COMMAND, CMD_READ_CONF);
        send(OP_READ, 8'h00);
        send(OP_COMMAND, CMD_ERASE);
        send_addr(0, 196608, 3);
        send(OP_COMMAND, CMD_ERASE_CONF);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_config(8'd0, 8'd0);
                1: write_config(8'd255, 8'hFF);
                2: write_config(8'($urandom), 8'($urandom));
                default: write_config(8'd3, 8'($urandom));
            endcase
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            if (phase == 0)
                hold_cycles = 400;
            items_sent = 0;
            while (items_sent < 490)
                random_sequence();
            drain();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
